@@ rtl/esma_pkg.sv @@
// Shared constants and types for the event saliency map accumulator.
// Map geometry, response limits, item action codes and controller states.
// No dependencies.
package esma_pkg;

    localparam int MAP_SIDE  = 32;
    localparam int MAP_CELLS = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W    = $clog2(MAP_CELLS);

    localparam int RESP_W  = 8;
    localparam int STAMP_W = 32;

    localparam logic signed [RESP_W:0] RESP_MAX    = 9'sd127;
    localparam logic signed [RESP_W:0] DECAY_LEVEL = 9'sd20;
    localparam logic signed [RESP_W:0] MID_LEVEL   = 9'sd127;

    localparam logic ACT_EVENT = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

@@ rtl/esma_if.sv @@
// Channel interfaces of the event saliency map accumulator.
// Input item channel, display pixel channel and configuration write channel.
// No dependencies.
interface esma_item_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [4:0]  event_x;
    logic [4:0]  event_y;
    logic        polarity;
    logic [31:0] event_time;
    logic [31:0] window_low;
    logic [31:0] window_high;
    logic [9:0]  pixel_index;
    logic        decay_now;

    modport source (
        output valid, action, event_x, event_y, polarity, event_time,
               window_low, window_high, pixel_index, decay_now,
        input  ready
    );
    modport sink (
        input  valid, action, event_x, event_y, polarity, event_time,
               window_low, window_high, pixel_index, decay_now,
        output ready
    );
endinterface

interface esma_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_value;

    modport source (output valid, pixel_value, input ready);
    modport sink (input valid, pixel_value, output ready);
endinterface

interface esma_cfg_if;
    logic valid;
    logic ready;
    logic tristate_mode;

    modport source (output valid, tristate_mode, input ready);
    modport sink (input valid, tristate_mode, output ready);
endinterface

@@ rtl/esma_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// Read data holds until the next read enable.
// No dependencies.
module esma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/event_saliency_map_accumulator.sv @@
// Top level of the event saliency map accumulator: response and timestamp
// maps in two RAMs, read-modify-write controller and display output register.
// Depends on esma_pkg, esma_if and esma_ram.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------
//  item    | in  | valid / ready | action, event fields, window, pixel_index
//  pixel   | out | valid / ready | pixel_value
//  cfg     | in  | valid / ready | tristate_mode
//
// Each item is read from the registered map RAM ports when it is accepted, then
// the entry is modified and written back from the lookup state.
// After reset a clearing pass zeroes all MAP_CELLS (1024) cells of both maps,
// during which no item is taken; configuration writes are taken at any time.
// A read item whose result finds the pixel register full holds until the
// register is taken; the pixel register frees the next item from that stall.
module event_saliency_map_accumulator (
    input logic          clk,
    input logic          rst_n,
    esma_item_if.sink    item,
    esma_pixel_if.source pixel,
    esma_cfg_if.sink     cfg
);
    import esma_pkg::*;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               tri_reg;
    logic               act_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               pol_reg;
    logic               ev_ok_reg;
    logic               pix_ok_reg;
    logic               decay_reg;
    logic [STAMP_W-1:0] et_reg;
    logic [STAMP_W-1:0] wlo_reg;
    logic [STAMP_W-1:0] whi_reg;
    logic               pixel_valid_reg, pixel_valid_next;
    logic [7:0]         pixel_data_reg, pixel_data_next;

    logic               accept;
    logic               advance;
    logic               clr_last;
    logic               ev_in_window;
    logic               ev_coord_ok;
    logic               ev_ok;
    logic               pix_ok;
    logic [ADDR_W-1:0]  ev_addr;
    logic [ADDR_W-1:0]  rd_addr;

    logic               resp_we;
    logic               stamp_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [RESP_W-1:0]  resp_wdata;
    logic [STAMP_W-1:0] stamp_wdata;
    logic [RESP_W-1:0]  resp_rdata;
    logic [STAMP_W-1:0] stamp_rdata;

    logic signed [RESP_W:0] v9;
    logic signed [RESP_W:0] sum_up;
    logic signed [RESP_W:0] sum_dn;
    logic signed [RESP_W:0] ev_val;
    logic signed [RESP_W:0] mag;
    logic signed [RESP_W:0] dec_val;
    logic                   dec_hit;
    logic                   live;
    logic [7:0]             byte_val;

    // item decode
    assign ev_in_window = (item.event_time > item.window_low)
                       && (item.event_time < item.window_high);
    assign ev_coord_ok  = (int'(item.event_x) < MAP_SIDE) && (int'(item.event_y) < MAP_SIDE);
    assign ev_ok        = ev_in_window && (item.event_y != 5'd1) && ev_coord_ok;
    assign pix_ok       = int'(item.pixel_index) < MAP_CELLS;
    assign ev_addr      = ADDR_W'((MAP_SIDE - 1 - int'(item.event_x))
                        + (MAP_SIDE - 1 - int'(item.event_y)) * MAP_SIDE);
    assign rd_addr      = (item.action == ACT_EVENT) ? ev_addr
                                                     : ADDR_W'(item.pixel_index);

    assign accept   = item.valid && item.ready;
    assign advance  = (act_reg == ACT_EVENT) || !pixel_valid_reg || pixel.ready;
    assign clr_last = clr_cnt_reg == ADDR_W'(MAP_CELLS - 1);

    assign cfg.ready   = 1'b1;
    assign pixel.valid = pixel_valid_reg;
    assign pixel.pixel_value = pixel_data_reg;

    // modify stage
    always_comb
    begin
        v9     = {resp_rdata[RESP_W-1], resp_rdata};
        sum_up = v9 + RESP_MAX;
        sum_dn = v9 - RESP_MAX;
        if (pol_reg)
        begin
            ev_val = (sum_up > RESP_MAX) ? RESP_MAX : sum_up;
        end
        else
        begin
            ev_val = (sum_dn < -RESP_MAX) ? -RESP_MAX : sum_dn;
        end

        mag  = v9[RESP_W] ? -v9 : v9;
        live = (stamp_rdata > wlo_reg) && (stamp_rdata < whi_reg);

        dec_hit = 1'b0;
        dec_val = v9;
        if (v9 > DECAY_LEVEL)
        begin
            dec_hit = decay_reg;
            dec_val = v9 - 9'sd1;
        end
        else if (tri_reg && (v9 < -DECAY_LEVEL))
        begin
            dec_hit = decay_reg;
            dec_val = v9 + 9'sd1;
        end

        if (!pix_ok_reg)
        begin
            byte_val = 8'd0;
        end
        else if (tri_reg)
        begin
            byte_val = live ? 8'(MID_LEVEL + v9) : 8'(MID_LEVEL);
        end
        else
        begin
            byte_val = live ? {mag[6:0], 1'b0} : 8'd0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        item.ready       = 1'b0;
        resp_we          = 1'b0;
        stamp_we         = 1'b0;
        wr_addr          = addr_reg;
        resp_wdata       = ev_val[RESP_W-1:0];
        stamp_wdata      = et_reg;
        clr_cnt_next     = clr_cnt_reg;
        pixel_valid_next = pixel_valid_reg && !pixel.ready;
        pixel_data_next  = pixel_data_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                resp_we      = 1'b1;
                stamp_we     = 1'b1;
                wr_addr      = clr_cnt_reg;
                resp_wdata   = '0;
                stamp_wdata  = '0;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                item.ready = 1'b1;
            end
            ST_LOOKUP:
            begin
                if (act_reg == ACT_EVENT)
                begin
                    resp_we  = ev_ok_reg;
                    stamp_we = ev_ok_reg;
                end
                else if (advance)
                begin
                    resp_we          = pix_ok_reg && dec_hit;
                    resp_wdata       = dec_val[RESP_W-1:0];
                    pixel_valid_next = 1'b1;
                    pixel_data_next  = byte_val;
                end
            end
            default:
            begin
                item.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            tri_reg         <= 1'b0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            pixel_valid_reg <= pixel_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                tri_reg <= cfg.tristate_mode;
            end
        end
    end

    // hold the accepted item for the write-back cycle
    always_ff @(posedge clk)
    begin
        pixel_data_reg <= pixel_data_next;
        if (accept)
        begin
            act_reg    <= item.action;
            addr_reg   <= rd_addr;
            pol_reg    <= item.polarity;
            ev_ok_reg  <= ev_ok;
            pix_ok_reg <= pix_ok;
            decay_reg  <= item.decay_now;
            et_reg     <= item.event_time;
            wlo_reg    <= item.window_low;
            whi_reg    <= item.window_high;
        end
    end

    esma_ram #(
        .WIDTH (RESP_W),
        .DEPTH (MAP_CELLS)
    ) u_resp_ram (
        .clk   (clk),
        .we    (resp_we),
        .waddr (wr_addr),
        .wdata (resp_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (resp_rdata)
    );

    esma_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (MAP_CELLS)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (stamp_we),
        .waddr (wr_addr),
        .wdata (stamp_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (stamp_rdata)
    );

endmodule

@@ dv/event_saliency_map_accumulator_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the event saliency map accumulator: directed and random items,
// a shadow copy of both maps predicting each display pixel, random idling on both channels.
// Depends on esma_pkg, esma_if and the event_saliency_map_accumulator RTL.
module event_saliency_map_accumulator_test;
    import esma_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE_TICKS = 4;
    localparam int IGNORED_ROW  = 1;
    localparam logic [31:0] TIME_TOP = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        action;
        logic [4:0]  event_x;
        logic [4:0]  event_y;
        logic        polarity;
        logic [31:0] event_time;
        logic [31:0] window_low;
        logic [31:0] window_high;
        logic [9:0]  pixel_index;
        logic        decay_now;
    } map_item_t;

    logic clk;
    logic rst_n;

    esma_item_if  item_ch();
    esma_pixel_if pixel_ch();
    esma_cfg_if   cfg_ch();

    event_saliency_map_accumulator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .pixel (pixel_ch),
        .cfg   (cfg_ch)
    );

    logic signed [RESP_W-1:0] shadow_resp [MAP_CELLS];
    logic [STAMP_W-1:0]       shadow_stamp [MAP_CELLS];
    logic                     shadow_tristate;

    logic [7:0]  expected_pixels [$];
    int          mismatches;
    int          quiet_cycles;
    int          burst_left;
    logic [31:0] now_tick;
    int          hot_count;
    logic [4:0]  hot_x [8];
    logic [4:0]  hot_y [8];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit in_window(input logic [31:0] t, input logic [31:0] lo,
                                     input logic [31:0] hi);
        return (t > lo) && (t < hi);
    endfunction

    function automatic logic [9:0] mirror_addr(input logic [4:0] x, input logic [4:0] y);
        return 10'((MAP_SIDE - 1 - int'(x)) + (MAP_SIDE - 1 - int'(y)) * MAP_SIDE);
    endfunction

    function automatic bit shadow_apply(input map_item_t it, output logic [7:0] px);
        int unsigned pos;
        int v;
        int mag;
        int lim;
        int decay_lvl;
        int mid;
        lim = RESP_MAX;
        decay_lvl = DECAY_LEVEL;
        mid = MID_LEVEL;
        px = 8'd0;
        if (it.action == ACT_EVENT)
        begin
            if (!in_window(it.event_time, it.window_low, it.window_high) ||
                it.event_y == IGNORED_ROW)
                return 0;
            pos = mirror_addr(it.event_x, it.event_y);
            v = shadow_resp[pos];
            if (it.polarity)
                v = (v + lim > lim) ? lim : v + lim;
            else
                v = (v - lim < -lim) ? -lim : v - lim;
            shadow_resp[pos] = 8'(v);
            shadow_stamp[pos] = it.event_time;
            return 0;
        end
        pos = it.pixel_index;
        v = shadow_resp[pos];
        if (shadow_tristate)
        begin
            px = in_window(shadow_stamp[pos], it.window_low, it.window_high) ? 8'(mid + v)
                                                                              : 8'(mid);
            if (it.decay_now && v > decay_lvl)
                shadow_resp[pos] = 8'(v - 1);
            else if (it.decay_now && v < -decay_lvl)
                shadow_resp[pos] = 8'(v + 1);
        end
        else
        begin
            mag = (v < 0) ? -v : v;
            px = in_window(shadow_stamp[pos], it.window_low, it.window_high) ? 8'(2 * mag)
                                                                              : 8'd0;
            if (it.decay_now && v > decay_lvl)
                shadow_resp[pos] = 8'(v - 1);
        end
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s, got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : score
        logic [7:0] want;
        map_item_t  seen;
        if (rst_n)
        begin
            if (pixel_ch.valid && pixel_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                    report_mismatch("pixel with none pending", pixel_ch.pixel_value, 8'd0);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_ch.pixel_value !== want)
                        report_mismatch("pixel_value", pixel_ch.pixel_value, want);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                shadow_tristate = cfg_ch.tristate_mode;
            if (item_ch.valid && item_ch.ready)
            begin
                seen.action      = item_ch.action;
                seen.event_x     = item_ch.event_x;
                seen.event_y     = item_ch.event_y;
                seen.polarity    = item_ch.polarity;
                seen.event_time  = item_ch.event_time;
                seen.window_low  = item_ch.window_low;
                seen.window_high = item_ch.window_high;
                seen.pixel_index = item_ch.pixel_index;
                seen.decay_now   = item_ch.decay_now;
                if (shadow_apply(seen, want))
                    expected_pixels.push_back(want);
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (pixel_ch.valid && pixel_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int seg_left;
        int style;
        pixel_ch.ready = 1'b0;
        seg_left = 0;
        style = 0;
        forever
        begin
            @(negedge clk);
            if (seg_left == 0)
            begin
                style = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (style)
                0: pixel_ch.ready <= 1'b1;
                1: pixel_ch.ready <= ($urandom_range(0, 1) == 1);
                2: pixel_ch.ready <= ($urandom_range(0, 7) != 0);
                default: pixel_ch.ready <= ((seg_left % 17) < 3);
            endcase
        end
    end

    function automatic map_item_t noise_item();
        map_item_t it;
        it.action      = 1'($urandom);
        it.event_x     = 5'($urandom);
        it.event_y     = 5'($urandom);
        it.polarity    = 1'($urandom);
        it.event_time  = $urandom;
        it.window_low  = $urandom;
        it.window_high = $urandom;
        it.pixel_index = 10'($urandom);
        it.decay_now   = 1'($urandom);
        return it;
    endfunction

    function automatic map_item_t make_event(input logic [4:0] x, input logic [4:0] y,
                                             input logic pol, input logic [31:0] t,
                                             input logic [31:0] lo, input logic [31:0] hi);
        map_item_t it;
        it = noise_item();
        it.action = ACT_EVENT;
        it.event_x = x;
        it.event_y = y;
        it.polarity = pol;
        it.event_time = t;
        it.window_low = lo;
        it.window_high = hi;
        return it;
    endfunction

    function automatic map_item_t make_read(input logic [9:0] idx, input logic [31:0] lo,
                                            input logic [31:0] hi, input logic decay);
        map_item_t it;
        it = noise_item();
        it.action = ACT_READ;
        it.pixel_index = idx;
        it.window_low = lo;
        it.window_high = hi;
        it.decay_now = decay;
        return it;
    endfunction

    function automatic map_item_t random_item(input int event_pct);
        map_item_t it;
        int pick;
        int h;
        it = noise_item();
        now_tick += $urandom_range(0, 50);
        pick = $urandom_range(0, 99);
        h = $urandom_range(0, hot_count - 1);
        if (pick < event_pct)
            it = make_event(hot_x[h], hot_y[h], 1'($urandom), now_tick,
                            now_tick - $urandom_range(1, 500), now_tick + $urandom_range(1, 500));
        else if (pick < 86)
            it = make_read(mirror_addr(hot_x[h], hot_y[h]),
                           now_tick - (($urandom_range(0, 4) == 0) ? $urandom_range(0, 300)
                                                                   : $urandom_range(300, 60000)),
                           now_tick + $urandom_range(0, 100), ($urandom_range(0, 4) != 0));
        else if (pick < 93)
            it.action = ACT_EVENT;
        else
            it.action = ACT_READ;
        return it;
    endfunction

    task automatic send_item(input map_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        item_ch.valid       <= 1'b1;
        item_ch.action      <= it.action;
        item_ch.event_x     <= it.event_x;
        item_ch.event_y     <= it.event_y;
        item_ch.polarity    <= it.polarity;
        item_ch.event_time  <= it.event_time;
        item_ch.window_low  <= it.window_low;
        item_ch.window_high <= it.window_high;
        item_ch.pixel_index <= it.pixel_index;
        item_ch.decay_now   <= it.decay_now;
        do
            @(posedge clk);
        while (item_ch.ready !== 1'b1);
        @(negedge clk);
    endtask

    task automatic wait_for_pixels();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_ch.valid <= 1'b1;
        cfg_ch.tristate_mode <= mode;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        write_mode(1'b0);
        send_item(make_read(10'd1023, 32'd0, TIME_TOP, 1'b1));
    endtask

    task automatic test_magnitude_display();
        send_item(make_event(5'd0, 5'd0, 1'b1, 32'd100, 32'd50, 32'd200));
        send_item(make_read(10'd1023, 32'd50, 32'd200, 1'b0));
        send_item(make_event(5'd0, 5'd0, 1'b1, 32'd101, 32'd50, 32'd200));
        send_item(make_event(5'd31, 5'd31, 1'b0, 32'd100, 32'd99, 32'd101));
        send_item(make_event(5'd31, 5'd31, 1'b0, 32'd100, 32'd99, 32'd101));
        send_item(make_read(10'd0, 32'd99, 32'd101, 1'b1));
        send_item(make_event(5'd5, 5'd1, 1'b1, 32'd100, 32'd0, TIME_TOP));
        send_item(make_read(mirror_addr(5'd5, 5'd1), 32'd0, TIME_TOP, 1'b0));
        send_item(make_event(5'd7, 5'd9, 1'b1, 32'd200, 32'd200, 32'd300));
        send_item(make_event(5'd7, 5'd9, 1'b1, 32'd300, 32'd200, 32'd300));
        send_item(make_event(5'd7, 5'd9, 1'b1, TIME_TOP, 32'd0, TIME_TOP));
        send_item(make_read(mirror_addr(5'd7, 5'd9), 32'd0, TIME_TOP, 1'b1));
        send_item(make_event(5'd31, 5'd0, 1'b1, 32'd1, 32'd0, 32'd2));
        send_item(make_event(5'd0, 5'd31, 1'b0, TIME_TOP - 1, TIME_TOP - 2, TIME_TOP));
        send_item(make_read(mirror_addr(5'd31, 5'd0), 32'd0, 32'd2, 1'b1));
        send_item(make_read(mirror_addr(5'd0, 5'd31), TIME_TOP - 2, TIME_TOP, 1'b0));
        send_item(make_read(10'd1023, 32'd101, 32'd200, 1'b1));
        send_item(make_read(10'd1023, 32'd100, 32'd200, 1'b0));
        send_item(make_event(5'd0, 5'd0, 1'b0, 32'd150, 32'd50, 32'd200));
        send_item(make_read(10'd1023, 32'd100, 32'd200, 1'b1));
    endtask

    task automatic test_tristate_display();
        wait_for_pixels();
        write_mode(1'b1);
        send_item(make_read(10'd0, 32'd99, 32'd101, 1'b1));
        send_item(make_read(10'd0, 32'd99, 32'd101, 1'b0));
        send_item(make_read(10'd0, 32'd100, 32'd101, 1'b0));
        send_item(make_read(10'd1023, 32'd100, 32'd200, 1'b0));
        send_item(make_event(5'd3, 5'd4, 1'b1, 32'd500, 32'd499, 32'd501));
        send_item(make_read(mirror_addr(5'd3, 5'd4), 32'd499, 32'd501, 1'b1));
    endtask

    task automatic run_phase(input logic mode, input int hot_n, input int event_pct,
                             input int count);
        wait_for_pixels();
        write_mode(mode);
        hot_count = hot_n;
        now_tick = $urandom_range(100000, 32'hF000_0000);
        for (int i = 0; i < hot_n; i++)
        begin
            hot_x[i] = 5'($urandom);
            hot_y[i] = 5'($urandom);
            send_item(make_event(hot_x[i], hot_y[i], 1'($urandom), now_tick,
                                 now_tick - 1, now_tick + 1));
        end
        for (int i = 0; i < count; i++)
            send_item(random_item(event_pct));
    endtask

    task automatic test_random_traffic();
        run_phase(1'b1, 8, 40, 415);
        run_phase(1'b0, 4, 40, 415);
        run_phase(1'b1, 2, 1, 415);
        run_phase(1'b0, 2, 1, 415);
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.action = ACT_EVENT;
        item_ch.event_x = '0;
        item_ch.event_y = '0;
        item_ch.polarity = 1'b0;
        item_ch.event_time = '0;
        item_ch.window_low = '0;
        item_ch.window_high = '0;
        item_ch.pixel_index = '0;
        item_ch.decay_now = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.tristate_mode = 1'b0;
        mismatches = 0;
        burst_left = 0;
        hot_count = 1;
        now_tick = '0;
        shadow_tristate = 1'b0;
        for (int i = 0; i < MAP_CELLS; i++)
        begin
            shadow_resp[i] = '0;
            shadow_stamp[i] = '0;
        end
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_magnitude_display();
        test_tristate_display();
        test_random_traffic();

        wait_for_pixels();
        repeat (8) @(posedge clk);
        if (expected_pixels.size() != 0)
            report_mismatch("pixel never arrived", 8'd0, expected_pixels[0]);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/esma_pkg.sv
rtl/esma_if.sv
rtl/esma_ram.sv
rtl/event_saliency_map_accumulator.sv
dv/event_saliency_map_accumulator_test.sv
